[rtl/core/pia_register_interface_unit_macros.svh]
// ---------------------------------------------------------------------------
// pia_register_interface_unit_macros.svh
// assertion helpers shared by the checker
// ---------------------------------------------------------------------------
`ifndef PIA_REGISTER_INTERFACE_UNIT_MACROS_SVH
`define PIA_REGISTER_INTERFACE_UNIT_MACROS_SVH

// checked only outside reset
`define PIA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PIA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/pia_pkg.sv]
// ---------------------------------------------------------------------------
// pia_pkg
// types, register codes and state layout of the peripheral interface adapter
// ---------------------------------------------------------------------------
package pia_pkg;

  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_CA1    = 2'd2,
    MODE_CB1    = 2'd3
  } pia_mode_t;

  typedef enum logic [1:0] {
    REG_PORT_A  = 2'd0,
    REG_PORT_B  = 2'd1,
    REG_CTRL_A  = 2'd2,
    REG_CTRL_B  = 2'd3
  } pia_addr_t;

  typedef enum logic [1:0] {
    CB2_FLOAT   = 2'd0,
    CB2_HIGH    = 2'd1,
    CB2_LOW     = 2'd2,
    CB2_UNUSED  = 2'd3
  } pia_cb2_t;

  // control bits 5..3: CA2/CB2 line mode
  localparam logic [2:0] C2_IN_NEG      = 3'd0;
  localparam logic [2:0] C2_IN_NEG_IRQ  = 3'd1;
  localparam logic [2:0] C2_IN_POS      = 3'd2;
  localparam logic [2:0] C2_IN_POS_IRQ  = 3'd3;
  localparam logic [2:0] C2_OUT_HSHAKE  = 3'd4;
  localparam logic [2:0] C2_OUT_PULSE   = 3'd5;
  localparam logic [2:0] C2_OUT_LOW     = 3'd6;
  localparam logic [2:0] C2_OUT_HIGH    = 3'd7;

  // control register bit positions
  localparam int CTL_IRQ1   = 7;
  localparam int CTL_IRQ2   = 6;
  localparam int CTL_DDR_N  = 2;
  localparam int CTL_EDGE1  = 1;
  localparam int CTL_IEN1   = 0;

  typedef struct packed {
    pia_mode_t   mode;
    pia_addr_t   addr;
    logic [7:0]  write_data;
    logic        line_level;
    logic [15:0] port_in;
  } pia_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
    logic       ca2_level;
    logic       cb2_level;
    logic       irq_a1;
    logic       irq_a2;
    logic       irq_b1;
    logic       irq_b2;
  } pia_out_t;

  typedef struct packed {
    logic [7:0]  control_a;
    logic [7:0]  control_b;
    logic [15:0] output_reg;
    logic [15:0] direction_reg;
    logic        edge_pending_a;
    logic        edge_pending_b;
    pia_cb2_t    cb2_drive;
    logic        ca1_last;
    logic        cb1_last;
  } pia_state_t;

  localparam pia_state_t STATE_RESET = '{
    control_a:      8'h00,
    control_b:      8'h00,
    output_reg:     16'h0000,
    direction_reg:  16'h0000,
    edge_pending_a: 1'b0,
    edge_pending_b: 1'b0,
    cb2_drive:      CB2_FLOAT,
    ca1_last:       1'b1,
    cb1_last:       1'b1
  };

endpackage

[rtl/core/pia_step.sv]
// ---------------------------------------------------------------------------
// pia_step
// next register state and result for one bus access or line event
// ---------------------------------------------------------------------------
module pia_step (
  input  pia_pkg::pia_state_t st,
  input  pia_pkg::pia_in_t    item,
  output pia_pkg::pia_state_t st_nxt,
  output pia_pkg::pia_out_t   res
);
  import pia_pkg::*;

  logic [15:0] pins_old;
  logic [15:0] pins_new;
  logic [15:0] port_b_rd;
  logic [7:0]  rd;
  logic [7:0]  wd;

  assign pins_old  = st.output_reg | ~st.direction_reg;
  assign port_b_rd = ((item.port_in ^ st.output_reg) & st.direction_reg) ^ item.port_in;
  assign wd        = item.write_data;

  always_comb begin
    st_nxt = st;
    rd     = 8'h00;
    case (item.mode)
      MODE_READ: begin
        case (item.addr)
          REG_PORT_A: begin
            if (!st.control_a[CTL_DDR_N]) begin
              rd = st.direction_reg[7:0];
            end else begin
              rd = item.port_in[7:0] & pins_old[7:0];
              st_nxt.control_a[CTL_IRQ1] = 1'b0;
              st_nxt.control_a[CTL_IRQ2] = 1'b0;
            end
          end
          REG_PORT_B: begin
            if (!st.control_b[CTL_DDR_N]) begin
              rd = st.direction_reg[15:8];
            end else begin
              rd = port_b_rd[15:8];
              st_nxt.control_b[CTL_IRQ1] = 1'b0;
              st_nxt.control_b[CTL_IRQ2] = 1'b0;
            end
          end
          REG_CTRL_A: rd = st.control_a;
          default:    rd = st.control_b;
        endcase
      end
      MODE_WRITE: begin
        case (item.addr)
          REG_PORT_A: begin
            if (st.control_a[CTL_DDR_N]) begin
              st_nxt.output_reg[7:0] = wd;
            end else begin
              st_nxt.direction_reg[7:0] = wd;
            end
          end
          REG_PORT_B: begin
            if (st.control_b[CTL_DDR_N]) begin
              st_nxt.output_reg[15:8] = wd;
            end else begin
              st_nxt.direction_reg[15:8] = wd;
            end
          end
          REG_CTRL_A: begin
            case (wd[5:3])
              C2_IN_NEG, C2_IN_NEG_IRQ, C2_OUT_PULSE: begin
                st_nxt.edge_pending_a = 1'b0;
              end
              C2_IN_POS, C2_IN_POS_IRQ: begin
                if (st.edge_pending_a) begin
                  st_nxt.edge_pending_a = 1'b0;
                  st_nxt.control_a[CTL_IRQ2] = 1'b1;
                end
              end
              C2_OUT_LOW: st_nxt.edge_pending_a = 1'b1;
              default: ;
            endcase
            if (wd[5]) begin
              st_nxt.control_a[CTL_IRQ2] = 1'b0;
            end
            st_nxt.control_a[5:0] = wd[5:0];
          end
          default: begin
            case (wd[5:3])
              C2_IN_NEG, C2_IN_NEG_IRQ, C2_IN_POS, C2_IN_POS_IRQ: begin
                if (st.edge_pending_b) begin
                  st_nxt.edge_pending_b = 1'b0;
                  st_nxt.control_b[CTL_IRQ2] = 1'b1;
                end
                st_nxt.cb2_drive = CB2_FLOAT;
              end
              C2_OUT_HSHAKE: st_nxt.edge_pending_b = 1'b0;
              C2_OUT_PULSE: begin
                st_nxt.edge_pending_b = 1'b0;
                st_nxt.cb2_drive      = CB2_HIGH;
              end
              C2_OUT_LOW: begin
                st_nxt.edge_pending_b = 1'b0;
                st_nxt.cb2_drive      = CB2_LOW;
              end
              default: begin
                // releasing a low CB2 counts as an edge
                if (st.cb2_drive == CB2_LOW) begin
                  st_nxt.edge_pending_b = 1'b1;
                end
                st_nxt.cb2_drive = CB2_HIGH;
              end
            endcase
            if (wd[5]) begin
              st_nxt.control_b[CTL_IRQ2] = 1'b0;
            end
            st_nxt.control_b[5:0] = wd[5:0];
          end
        endcase
      end
      MODE_CA1: begin
        if (st.ca1_last != item.line_level) begin
          st_nxt.ca1_last = item.line_level;
          if (st.control_a[CTL_IEN1] && !st.control_a[CTL_IRQ1] &&
              (st.control_a[CTL_EDGE1] == item.line_level)) begin
            st_nxt.control_a[CTL_IRQ1] = 1'b1;
          end
        end
      end
      default: begin
        if (st.cb1_last != item.line_level) begin
          st_nxt.cb1_last = item.line_level;
          if (st.control_b[CTL_IEN1] && !st.control_b[CTL_IRQ1] &&
              (st.control_b[CTL_EDGE1] == item.line_level)) begin
            st_nxt.control_b[CTL_IRQ1] = 1'b1;
          end
        end
      end
    endcase
  end

  assign pins_new = st_nxt.output_reg | ~st_nxt.direction_reg;

  always_comb begin
    res.read_data   = rd;
    res.port_a_pins = pins_new[7:0];
    res.port_b_pins = pins_new[15:8];
    res.ca2_level   = (st_nxt.control_a[5:3] != C2_OUT_LOW);
    res.cb2_level   = (st_nxt.control_b[5:3] != C2_OUT_LOW);
    res.irq_a1      = st_nxt.control_a[CTL_IRQ1];
    res.irq_a2      = st_nxt.control_a[6] && !st_nxt.control_a[5] && st_nxt.control_a[3];
    res.irq_b1      = st_nxt.control_b[CTL_IRQ1];
    res.irq_b2      = st_nxt.control_b[6] && !st_nxt.control_b[5] && st_nxt.control_b[3];
  end

endmodule

[rtl/core/pia_register_interface_unit.sv]
// ---------------------------------------------------------------------------
// pia_register_interface_unit
// two-port peripheral interface adapter, one bus access or line event per transfer
// ---------------------------------------------------------------------------
//   channel | direction | handshake               | payload
//   in_     | input     | in_valid / in_stall     | pia_in_t  (mode, addr, data, level, pins)
//   out_    | output    | out_valid / out_stall   | pia_out_t (read data, pins, lines, irqs)
//
// one transfer per cycle while in_stall is low; a result is presented after its input
// transfer has gone through the input register and then one pass of pia_step into the
// result register; a result-side stall can hold the item in the input register
// rst_n is synchronous: valid flags and state_r take reset values, both sides empty
// a stalled result holds; the input register still fills behind it, and in_stall
// rises only when both the input register and the result register are occupied
// ---------------------------------------------------------------------------
module pia_register_interface_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pia_pkg::pia_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pia_pkg::pia_out_t out_data
);
  import pia_pkg::*;

  logic       stage_valid_r;
  pia_in_t    stage_r;
  pia_state_t state_r;
  pia_state_t state_nxt;
  logic       out_valid_r;
  pia_out_t   out_r;
  pia_out_t   out_nxt;
  logic       advance;
  logic       in_xfer;

  pia_step u_step (
    .st     (state_r),
    .item   (stage_r),
    .st_nxt (state_nxt),
    .res    (out_nxt)
  );

  // item in the input register moves on when the result slot frees up
  assign advance  = stage_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = stage_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      state_r       <= STATE_RESET;
    end else begin
      if (in_xfer) begin
        stage_valid_r <= 1'b1;
      end else if (advance) begin
        stage_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/core/pia_chk.sv]
// ---------------------------------------------------------------------------
// pia_chk
// port-level checks on the adapter's transfer behavior
// ---------------------------------------------------------------------------
`include "pia_register_interface_unit_macros.svh"

module pia_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input pia_pkg::pia_out_t out_data
);
  import pia_pkg::*;

  logic in_xfer;
  logic out_free;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // stalled result holds
  `PIA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

  // with an empty result slot the input side never stalls
  `PIA_ASSERT(a_no_stall_empty, !out_valid |-> !in_stall, "input stalled with empty output")

  // an accepted transfer produces a result when the result slot is free to take it
  `PIA_ASSERT(a_latency, in_xfer ##1 out_free |=> out_valid, "accepted item did not produce a result")

  // reset empties the result slot
  `PIA_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind pia_register_interface_unit pia_chk u_pia_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/sv/tb_pia_register_interface_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_pia_register_interface_unit
// self-checking bench for the two-port peripheral interface adapter
// ---------------------------------------------------------------------------
// bus reads, bus writes and CA1/CB1 line events are pushed through the input
// channel with random gaps; a predictor tracks the port, direction and control
// registers and the pending-edge state, and every response is checked field by
// field; one phase holds the response side off long enough to stall the input
// ---------------------------------------------------------------------------
module tb_pia_register_interface_unit;
  import pia_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 8;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  pia_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  pia_out_t out_data;

  logic rx_stall;
  logic hold_stall;
  assign out_stall = rx_stall | hold_stall;

  pia_register_interface_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // predicted adapter state
  logic [7:0]  ctl_a;
  logic [7:0]  ctl_b;
  logic [15:0] out_reg;
  logic [15:0] ddr;
  logic        pend_a;
  logic        pend_b;
  pia_cb2_t    cb2_state;
  logic        ca1_prev;
  logic        cb1_prev;

  pia_out_t expected_responses[$];

  int  mismatch_count;
  int  responses_checked;
  int  n_reads;
  int  n_writes;
  int  n_line_events;
  int  cycle_count;
  bit  in_throttle;
  bit  rx_throttle;
  event hold_start;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // CA1/CB1 edge: sets the irq1 flag when enabled, clear and the edge matches
  function automatic logic [7:0] flag_edge(logic [7:0] ctl, logic prev, logic level);
    if (prev != level && ctl[CTL_IEN1] && !ctl[CTL_IRQ1] && ctl[CTL_EDGE1] == level)
      return ctl | 8'h80;
    return ctl;
  endfunction

  function automatic pia_out_t predict_response(pia_in_t it);
    pia_out_t   r;
    logic [15:0] pins;
    logic [2:0]  sel;
    r    = '0;
    pins = out_reg | ~ddr;
    sel  = it.write_data[5:3];
    case (it.mode)
      MODE_READ: begin
        case (it.addr)
          REG_PORT_A: begin
            if (!ctl_a[CTL_DDR_N]) begin
              r.read_data = ddr[7:0];
            end else begin
              ctl_a[7:6]  = 2'b00;
              r.read_data = it.port_in[7:0] & pins[7:0];
            end
          end
          REG_PORT_B: begin
            if (!ctl_b[CTL_DDR_N]) begin
              r.read_data = ddr[15:8];
            end else begin
              ctl_b[7:6]  = 2'b00;
              // output bits come from the register, input bits from the pins
              r.read_data = (out_reg[15:8] & ddr[15:8]) | (it.port_in[15:8] & ~ddr[15:8]);
            end
          end
          REG_CTRL_A: r.read_data = ctl_a;
          default:    r.read_data = ctl_b;
        endcase
      end
      MODE_WRITE: begin
        case (it.addr)
          REG_PORT_A: begin
            if (ctl_a[CTL_DDR_N]) out_reg[7:0] = it.write_data;
            else ddr[7:0] = it.write_data;
          end
          REG_PORT_B: begin
            if (ctl_b[CTL_DDR_N]) out_reg[15:8] = it.write_data;
            else ddr[15:8] = it.write_data;
          end
          REG_CTRL_A: begin
            case (sel)
              C2_IN_NEG, C2_IN_NEG_IRQ, C2_OUT_PULSE: pend_a = 1'b0;
              C2_IN_POS, C2_IN_POS_IRQ: begin
                if (pend_a) begin
                  pend_a = 1'b0;
                  ctl_a[CTL_IRQ2] = 1'b1;
                end
              end
              C2_OUT_LOW: pend_a = 1'b1;
              default: ;
            endcase
            if (sel[2]) ctl_a[CTL_IRQ2] = 1'b0;
            ctl_a = {ctl_a[7:6], it.write_data[5:0]};
          end
          default: begin
            case (sel)
              C2_IN_NEG, C2_IN_NEG_IRQ, C2_IN_POS, C2_IN_POS_IRQ: begin
                if (pend_b) begin
                  pend_b = 1'b0;
                  ctl_b[CTL_IRQ2] = 1'b1;
                end
                cb2_state = CB2_FLOAT;
              end
              C2_OUT_HSHAKE: pend_b = 1'b0;
              C2_OUT_PULSE: begin
                pend_b    = 1'b0;
                cb2_state = CB2_HIGH;
              end
              C2_OUT_LOW: begin
                pend_b    = 1'b0;
                cb2_state = CB2_LOW;
              end
              default: begin
                // leaving output-low for output-high arms the pending edge
                if (cb2_state == CB2_LOW) pend_b = 1'b1;
                cb2_state = CB2_HIGH;
              end
            endcase
            if (sel[2]) ctl_b[CTL_IRQ2] = 1'b0;
            ctl_b = {ctl_b[7:6], it.write_data[5:0]};
          end
        endcase
      end
      MODE_CA1: begin
        ctl_a    = flag_edge(ctl_a, ca1_prev, it.line_level);
        ca1_prev = it.line_level;
      end
      default: begin
        ctl_b    = flag_edge(ctl_b, cb1_prev, it.line_level);
        cb1_prev = it.line_level;
      end
    endcase
    pins          = out_reg | ~ddr;
    r.port_a_pins = pins[7:0];
    r.port_b_pins = pins[15:8];
    r.ca2_level   = (ctl_a[5:3] != C2_OUT_LOW);
    r.cb2_level   = (ctl_b[5:3] != C2_OUT_LOW);
    r.irq_a1      = ctl_a[CTL_IRQ1];
    r.irq_a2      = ((ctl_a & 8'h68) == 8'h48);
    r.irq_b1      = ctl_b[CTL_IRQ1];
    r.irq_b2      = ((ctl_b & 8'h68) == 8'h48);
    return r;
  endfunction

  function automatic pia_in_t make_item(pia_mode_t m, pia_addr_t a, logic [7:0] wd,
                                        logic lvl, logic [15:0] pin_levels);
    pia_in_t it;
    it.mode       = m;
    it.addr       = a;
    it.write_data = wd;
    it.line_level = lvl;
    it.port_in    = pin_levels;
    return it;
  endfunction

  // one input transfer; the expectation is queued once the block takes it
  task automatic send_access(pia_in_t it);
    int gap;
    gap = in_throttle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_responses.push_back(predict_response(it));
    case (it.mode)
      MODE_READ:  n_reads++;
      MODE_WRITE: n_writes++;
      default:    n_line_events++;
    endcase
  endtask

  task automatic send_random_access();
    send_access(make_item(pia_mode_t'($urandom_range(0, 3)), pia_addr_t'($urandom_range(0, 3)),
                          8'($urandom), 1'($urandom), 16'($urandom)));
  endtask

  task automatic test_directed_ops();
    // reset contents, direction registers and data register access
    send_access(make_item(MODE_READ,  REG_CTRL_A, 8'h00, 1'b1, 16'h0000));
    send_access(make_item(MODE_READ,  REG_PORT_A, 8'hFF, 1'b0, 16'hFFFF));
    send_access(make_item(MODE_WRITE, REG_PORT_A, 8'hFF, 1'b0, 16'h0000));
    send_access(make_item(MODE_WRITE, REG_PORT_B, 8'h0F, 1'b1, 16'hFFFF));
    send_access(make_item(MODE_READ,  REG_PORT_B, 8'h00, 1'b0, 16'h1234));
    send_access(make_item(MODE_WRITE, REG_CTRL_A, 8'h04, 1'b1, 16'h0000));
    send_access(make_item(MODE_WRITE, REG_CTRL_B, 8'h3C, 1'b0, 16'hFFFF));
    send_access(make_item(MODE_WRITE, REG_PORT_A, 8'hA5, 1'b0, 16'h0000));
    send_access(make_item(MODE_WRITE, REG_PORT_B, 8'h00, 1'b1, 16'hFFFF));
    send_access(make_item(MODE_READ,  REG_PORT_A, 8'h00, 1'b0, 16'hFFFF));
    send_access(make_item(MODE_READ,  REG_PORT_B, 8'hFF, 1'b1, 16'h0000));
    send_access(make_item(MODE_READ,  REG_PORT_B, 8'h00, 1'b0, 16'hFFFF));
    // CA1 falling edge with the CA2 output-low mode arming the pending edge
    send_access(make_item(MODE_WRITE, REG_CTRL_A, 8'h35, 1'b1, 16'h0000));
    send_access(make_item(MODE_CA1,   REG_PORT_B, 8'hFF, 1'b0, 16'hFFFF));
    send_access(make_item(MODE_CA1,   REG_CTRL_B, 8'h00, 1'b0, 16'h0000));
    send_access(make_item(MODE_READ,  REG_CTRL_A, 8'h00, 1'b1, 16'h0000));
    send_access(make_item(MODE_WRITE, REG_CTRL_A, 8'h1F, 1'b0, 16'hFFFF));
    send_access(make_item(MODE_CA1,   REG_PORT_A, 8'h00, 1'b1, 16'h0000));
    send_access(make_item(MODE_READ,  REG_PORT_A, 8'h00, 1'b0, 16'hFFFF));
    // CB2 output-low to output-high, then an input mode picks up the edge
    send_access(make_item(MODE_WRITE, REG_CTRL_B, 8'h35, 1'b0, 16'h0000));
    send_access(make_item(MODE_WRITE, REG_CTRL_B, 8'h3F, 1'b1, 16'h0000));
    send_access(make_item(MODE_WRITE, REG_CTRL_B, 8'h0B, 1'b0, 16'hFFFF));
    send_access(make_item(MODE_CB1,   REG_PORT_A, 8'h00, 1'b0, 16'h0000));
    send_access(make_item(MODE_CB1,   REG_CTRL_A, 8'hFF, 1'b1, 16'hFFFF));
    send_access(make_item(MODE_READ,  REG_CTRL_B, 8'h00, 1'b0, 16'h0000));
    send_access(make_item(MODE_WRITE, REG_CTRL_B, 8'h2C, 1'b1, 16'h0000));
    send_access(make_item(MODE_READ,  REG_PORT_B, 8'h00, 1'b0, 16'hA5A5));
  endtask

  // control write pair, line activity, then data and control reads on one side
  task automatic send_irq_sequence();
    bit         side_b;
    logic [7:0] ctl;
    int         n_edges;
    side_b = 1'($urandom_range(0, 1));
    ctl    = 8'($urandom);
    ctl[5:3] = ($urandom_range(0, 1) != 0) ? C2_OUT_LOW : C2_OUT_HIGH;
    send_access(make_item(MODE_WRITE, side_b ? REG_CTRL_B : REG_CTRL_A, ctl, 1'($urandom),
                          16'($urandom)));
    ctl = 8'($urandom);
    ctl[CTL_IEN1] = ($urandom_range(0, 3) != 0);
    send_access(make_item(MODE_WRITE, side_b ? REG_CTRL_B : REG_CTRL_A, ctl, 1'($urandom),
                          16'($urandom)));
    n_edges = $urandom_range(1, 3);
    repeat (n_edges)
      send_access(make_item(side_b ? MODE_CB1 : MODE_CA1, pia_addr_t'($urandom_range(0, 3)),
                            8'($urandom), 1'($urandom), 16'($urandom)));
    send_access(make_item(MODE_READ, side_b ? REG_PORT_B : REG_PORT_A, 8'($urandom),
                          1'($urandom), 16'($urandom)));
    send_access(make_item(MODE_READ, side_b ? REG_CTRL_B : REG_CTRL_A, 8'($urandom),
                          1'($urandom), 16'($urandom)));
  endtask

  task automatic test_random_traffic(int n_items);
    int start_count;
    int next_shuffle;
    start_count  = n_reads + n_writes + n_line_events;
    next_shuffle = 0;
    while (n_reads + n_writes + n_line_events - start_count < n_items) begin
      if (n_reads + n_writes + n_line_events - start_count >= next_shuffle) begin
        in_throttle  = ($urandom_range(0, 3) != 0);
        rx_throttle  = ($urandom_range(0, 3) != 0);
        next_shuffle = next_shuffle + $urandom_range(50, 150);
      end
      if ($urandom_range(0, 9) < 3) send_irq_sequence();
      else send_random_access();
    end
    in_throttle = 1'b1;
    rx_throttle = 1'b1;
  endtask

  task automatic test_backpressure();
    in_throttle = 1'b0;
    -> hold_start;
    repeat (24) send_random_access();
    in_throttle = 1'b1;
  endtask

  // long response hold-off, counted here so the input side backs up
  initial begin : hold_off
    hold_stall <= 1'b0;
    forever begin
      @(hold_start);
      hold_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_stall <= 1'b0;
    end
  end

  initial begin : response_sink
    int pause;
    rx_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall && rx_throttle) begin
        pause = $urandom_range(0, 10);
        if (pause > 0) begin
          rx_stall <= 1'b1;
          repeat (pause) @(posedge clk);
          rx_stall <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : check_response
    pia_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_responses.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected transfer, expected none, actual %h", $time, out_data);
      end else begin
        want = expected_responses.pop_front();
        responses_checked++;
        compare_field("read_data",   want.read_data,       out_data.read_data);
        compare_field("port_a_pins", want.port_a_pins,     out_data.port_a_pins);
        compare_field("port_b_pins", want.port_b_pins,     out_data.port_b_pins);
        compare_field("ca2_level",   8'(want.ca2_level),   8'(out_data.ca2_level));
        compare_field("cb2_level",   8'(want.cb2_level),   8'(out_data.cb2_level));
        compare_field("irq_a1",      8'(want.irq_a1),      8'(out_data.irq_a1));
        compare_field("irq_a2",      8'(want.irq_a2),      8'(out_data.irq_a2));
        compare_field("irq_b1",      8'(want.irq_b1),      8'(out_data.irq_b1));
        compare_field("irq_b2",      8'(want.irq_b2),      8'(out_data.irq_b2));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d responses outstanding", $time, expected_responses.size());
      $display("** pia_register_interface_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    ctl_a     = 8'h00;
    ctl_b     = 8'h00;
    out_reg   = 16'h0000;
    ddr       = 16'h0000;
    pend_a    = 1'b0;
    pend_b    = 1'b0;
    cb2_state = CB2_FLOAT;
    ca1_prev  = 1'b1;
    cb1_prev  = 1'b1;
    mismatch_count    = 0;
    responses_checked = 0;
    n_reads       = 0;
    n_writes      = 0;
    n_line_events = 0;
    cycle_count   = 0;
    in_throttle   = 1'b1;
    rx_throttle   = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_random_traffic(1200);
    test_backpressure();
    test_random_traffic(60);

    in_valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d bus reads, %0d bus writes and %0d CA1/CB1 line events",
             n_reads, n_writes, n_line_events);
    $display("%0d responses compared, %0d field mismatches", responses_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** pia_register_interface_unit: PASSED **");
    end else begin
      $display("** pia_register_interface_unit: FAILED **");
    end
    $finish;
  end

endmodule
